// ----- hdl/mfrd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mfrd_pkg;

    localparam int KNOWN_KINDS = 10;
    localparam int KIND_COUNT  = 10;

    localparam logic [3:0] TRIP_KIND    = 4'd9;
    localparam logic [3:0] LOAD_KIND    = 4'd8;
    localparam logic [3:0] NO_KIND      = 4'(KNOWN_KINDS);

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CHECKSUM  = 3'd1;
    localparam logic [2:0] ST_ERROR     = 3'd2;
    localparam logic [2:0] ST_OTHER     = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;

    localparam logic [7:0] CTRL_ERROR   = 8'hD1;
    localparam logic [7:0] CTRL_MASK    = 8'hF0;
    localparam logic [7:0] CTRL_OTHER   = 8'h10;
    localparam logic [7:0] VALUE_OFFSET = 8'h33;

    localparam logic [8:0] POS_ADDR_FIRST  = 9'd1;
    localparam logic [8:0] POS_ADDR_LAST   = 9'd6;
    localparam logic [8:0] POS_CONTROL     = 9'd8;
    localparam logic [8:0] POS_LENGTH      = 9'd9;
    localparam logic [8:0] POS_IDENT_FIRST = 9'd10;
    localparam logic [8:0] POS_IDENT_LAST  = 9'd13;
    localparam logic [8:0] POS_VALUE_FIRST = 9'd14;
    localparam logic [8:0] POS_VALUE_LAST  = 9'd17;

    localparam logic [26:0] READING_MAX = 27'd99999999;

    localparam logic [31:0] KIND_IDENT [KNOWN_KINDS] = '{
        32'h33343333, 32'h33353333, 32'h35343433, 32'h35353433, 32'h35363333,
        32'h35373333, 32'h35383333, 32'h35B33335, 32'h39333335, 32'h37333836
    };

    localparam logic [2:0] KIND_BYTES [KNOWN_KINDS] = '{
        3'd4, 3'd4, 3'd2, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd0, 3'd0
    };

    localparam logic [19:0] VALUE_WEIGHT [4] = '{20'd1, 20'd100, 20'd10000, 20'd1000000};

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_begin;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  item_kind;
        logic [47:0] meter_address;
        logic [26:0] reading;
        logic        relay_tripped;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  running_sum;
        logic [7:0]  control_code;
        logic [31:0] identifier;
        logic [47:0] address;
        logic [7:0]  first_value;
        logic [14:0] acc2;
        logic [20:0] acc3;
        logic [27:0] acc4;
    } t_frame_snap;

    // offset-removed BCD byte as high*10+low, at most 165
    function automatic logic [7:0] bcd_digit(input logic [7:0] b);
        logic [7:0] d;
        d = b - VALUE_OFFSET;
        return ({4'b0, d[7:4]} << 3) + ({4'b0, d[7:4]} << 1) + {4'b0, d[3:0]};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/meter_frame_response_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_in_item  (frame_byte, frame_begin)
// out       output     o_out_valid / i_out_ready o_out_item (status .. relay_tripped)
//
// One byte per cycle while the output is not held; a byte passes an input register,
// then the frame capture and result classify logic, and a result lands in the
// output register as its checksum byte leaves the input register. Synchronous
// active-low reset leaves the decoder waiting for a frame start. A held output
// stalls the input register, which still takes one more byte.

module meter_frame_response_decoder #(
    parameter int KIND_COUNT = mfrd_pkg::KIND_COUNT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire mfrd_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output mfrd_pkg::t_out_item      o_out_item
);
    import mfrd_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        advance;
    logic        check;
    t_frame_snap snap;
    t_out_item   result;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    mfrd_capture u_capture (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_frame_byte  (r_in_item.frame_byte),
        .i_frame_begin (r_in_item.frame_begin),
        .o_check       (check),
        .o_snap        (snap)
    );

    mfrd_classify #(
        .KIND_COUNT (KIND_COUNT)
    ) u_classify (
        .i_snap       (snap),
        .i_check_byte (r_in_item.frame_byte),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (check) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (check) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- hdl/mfrd_capture.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mfrd_capture (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic [7:0]            i_frame_byte,
    input  wire logic                  i_frame_begin,
    output logic                       o_check,
    output mfrd_pkg::t_frame_snap      o_snap
);
    import mfrd_pkg::*;

    logic [8:0]  r_pos,   n_pos;
    logic [7:0]  r_sum,   n_sum;
    logic [47:0] r_addr,  n_addr;
    logic [7:0]  r_ctrl,  n_ctrl;
    logic [7:0]  r_len,   n_len;
    logic [31:0] r_ident, n_ident;
    logic [7:0]  r_first, n_first;
    logic [14:0] r_acc2,  n_acc2;
    logic [20:0] r_acc3,  n_acc3;
    logic [27:0] r_acc4,  n_acc4;
    logic        r_done,  n_done;

    logic        is_check;
    logic [8:0]  cur_pos;
    logic [2:0]  addr_idx;
    logic [1:0]  ident_idx;
    logic [1:0]  value_idx;
    logic [27:0] prod;

    // position of the byte now in the input register
    assign cur_pos   = i_frame_begin ? 9'd0 : r_pos;
    assign addr_idx  = 3'(cur_pos - POS_ADDR_FIRST);
    assign ident_idx = 2'(cur_pos - POS_IDENT_FIRST);
    assign value_idx = 2'(cur_pos - POS_VALUE_FIRST);
    assign prod      = 28'(bcd_digit(i_frame_byte)) * 28'(VALUE_WEIGHT[value_idx]);

    always_comb begin
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_addr  = r_addr;
        n_ctrl  = r_ctrl;
        n_len   = r_len;
        n_ident = r_ident;
        n_first = r_first;
        n_acc2  = r_acc2;
        n_acc3  = r_acc3;
        n_acc4  = r_acc4;
        n_done  = r_done;
        is_check = 1'b0;
        if (i_frame_begin) begin
            n_pos   = '0;
            n_sum   = '0;
            n_addr  = '0;
            n_ctrl  = '0;
            n_len   = '0;
            n_ident = '0;
            n_first = VALUE_OFFSET;
            n_acc2  = '0;
            n_acc3  = '0;
            n_acc4  = '0;
            n_done  = 1'b0;
        end
        if (!n_done) begin
            if (n_pos >= POS_IDENT_FIRST && n_pos == POS_IDENT_FIRST + {1'b0, n_len}) begin
                is_check = 1'b1;
                n_done   = 1'b1;
            end else begin
                n_sum = n_sum + i_frame_byte;
                if (n_pos >= POS_ADDR_FIRST && n_pos <= POS_ADDR_LAST) begin
                    n_addr[8*addr_idx +: 8] = i_frame_byte;
                end else if (n_pos == POS_CONTROL) begin
                    n_ctrl = i_frame_byte;
                end else if (n_pos == POS_LENGTH) begin
                    n_len = i_frame_byte;
                end else if (n_pos >= POS_IDENT_FIRST && n_pos <= POS_IDENT_LAST) begin
                    n_ident[8*ident_idx +: 8] = i_frame_byte;
                end else if (n_pos >= POS_VALUE_FIRST && n_pos <= POS_VALUE_LAST) begin
                    if (value_idx == 2'd0) begin
                        n_first = i_frame_byte;
                    end
                    n_acc4 = n_acc4 + prod;
                    if (value_idx < 2'd3) begin
                        n_acc3 = n_acc3 + prod[20:0];
                    end
                    if (value_idx < 2'd2) begin
                        n_acc2 = n_acc2 + prod[14:0];
                    end
                end
                n_pos = n_pos + 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sum   <= '0;
            r_addr  <= '0;
            r_ctrl  <= '0;
            r_len   <= '0;
            r_ident <= '0;
            r_first <= VALUE_OFFSET;
            r_acc2  <= '0;
            r_acc3  <= '0;
            r_acc4  <= '0;
            r_done  <= 1'b1;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_addr  <= n_addr;
            r_ctrl  <= n_ctrl;
            r_len   <= n_len;
            r_ident <= n_ident;
            r_first <= n_first;
            r_acc2  <= n_acc2;
            r_acc3  <= n_acc3;
            r_acc4  <= n_acc4;
            r_done  <= n_done;
        end
    end

    assign o_check = i_step && is_check;

    always_comb begin
        o_snap.running_sum  = r_sum;
        o_snap.control_code = r_ctrl;
        o_snap.identifier   = r_ident;
        o_snap.address      = r_addr;
        o_snap.first_value  = r_first;
        o_snap.acc2         = r_acc2;
        o_snap.acc3         = r_acc3;
        o_snap.acc4         = r_acc4;
    end

endmodule

`default_nettype wire

// ----- hdl/mfrd_classify.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mfrd_classify #(
    parameter int KIND_COUNT = mfrd_pkg::KIND_COUNT
) (
    input  wire mfrd_pkg::t_frame_snap i_snap,
    input  wire logic [7:0]            i_check_byte,
    output mfrd_pkg::t_out_item        o_result
);
    import mfrd_pkg::*;

    localparam int KIND_LIMIT = (KIND_COUNT < KNOWN_KINDS) ? KIND_COUNT : KNOWN_KINDS;

    logic [3:0] found;
    logic [7:0] first_diff;

    always_comb begin
        found = NO_KIND;
        for (int i = KIND_LIMIT - 1; i >= 0; i--) begin
            if (i_snap.identifier == KIND_IDENT[i]) begin
                found = 4'(i);
            end
        end
    end

    assign first_diff = i_snap.first_value - VALUE_OFFSET;

    always_comb begin
        o_result.status        = ST_OK;
        o_result.item_kind     = '0;
        o_result.meter_address = i_snap.address;
        o_result.reading       = '0;
        o_result.relay_tripped = 1'b0;
        if (i_check_byte != i_snap.running_sum) begin
            o_result.status = ST_CHECKSUM;
        end else if (i_snap.control_code == CTRL_ERROR) begin
            o_result.status = ST_ERROR;
        end else if ((i_snap.control_code & CTRL_MASK) == CTRL_OTHER) begin
            o_result.status = ST_OTHER;
        end else if (found == NO_KIND || found == LOAD_KIND) begin
            o_result.status = ST_UNKNOWN;
        end else begin
            o_result.item_kind = found;
            if (found == TRIP_KIND) begin
                o_result.relay_tripped = first_diff[4];
            end else begin
                case (KIND_BYTES[found])
                    3'd4:    o_result.reading = (i_snap.acc4 > 28'(READING_MAX)) ?
                                 READING_MAX : i_snap.acc4[26:0];
                    3'd3:    o_result.reading = 27'(i_snap.acc3);
                    3'd2:    o_result.reading = 27'(i_snap.acc2);
                    default: o_result.reading = '0;
                endcase
            end
        end
    end

endmodule

`default_nettype wire
